// ----- rtl/hftp_pkg.sv -----
// ----------------------------------------------------------------------------
// hftp_pkg: shared constants for the two-point heading unit
// Datapath widths, the normalization window and the arctangent table
// expressed in fractions of a full turn (2^32 per turn).
// ----------------------------------------------------------------------------
package hftp_pkg;

	// Width of the rotation datapath. Normalized vectors stay below 2^62.
	localparam int DP_BITS = 64;

	// Normalization window: the larger magnitude is shifted up to bit NORM_MSB.
	localparam int NORM_BITS = 60;
	localparam int NORM_MSB  = NORM_BITS - 1;

	// Angle accumulator, 2^32 per turn.
	localparam int ACC_BITS = 32;
	localparam logic [ACC_BITS-1:0] HALF_TURN = 32'h8000_0000;

	// Longest rotation chain that the table supports.
	localparam int MAX_STEPS = 32;

	// atan(2^-i) / (2*pi) * 2^32, rounded to nearest.
	localparam logic [ACC_BITS-1:0] TURN_ATAN [MAX_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

endpackage

// ----- rtl/heading_from_two_points_top.sv -----
// Pipeline from an accepted request to its result: difference, half-plane
// fold, three normalize stages, one stage per rotation step, output register.
// Rotation steps are capped at 32.
// Throughput: one request per cycle while the output register is empty or read;
// every stage is a register, and a stall at the output freezes every stage.
// Reset: arst_n clears all valid bits asynchronously; data registers are not reset.
// ----------------------------------------------------------------------------
// heading_from_two_points_top: heading of a vector as a fraction of a turn
// Subtracts two points, folds the left half-plane, normalizes the vector and
// runs a fully pipelined CORDIC vectoring chain to find atan2 in turns.
// ----------------------------------------------------------------------------
module heading_from_two_points_top #(
	parameter int COORD_BITS   = 32,
	parameter int ANGLE_BITS   = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         pair_present,
	input  logic signed [COORD_BITS-1:0] first_x,
	input  logic signed [COORD_BITS-1:0] first_y,
	input  logic signed [COORD_BITS-1:0] second_x,
	input  logic signed [COORD_BITS-1:0] second_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic        [ANGLE_BITS-1:0] heading
);
	import hftp_pkg::*;

	// Number of rotation stages actually built.
	localparam int N_STEPS = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;
	localparam int EXT     = DP_BITS - COORD_BITS;

	// The whole pipeline moves together. It advances whenever the output
	// register is empty or its result is being taken in this cycle, so a
	// stall freezes every stage and nothing is dropped or repeated.
	logic advance;

	assign advance  = !out_valid || out_ready;
	assign in_ready = advance;

	// ------------------------------------------------------------------
	// Stage 1: exact differences, sign-extended to the datapath width.
	// ------------------------------------------------------------------
	logic                      v_s1;
	logic                      present_s1;
	logic signed [DP_BITS-1:0] dx_s1;
	logic signed [DP_BITS-1:0] dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			present_s1 <= pair_present;
			dx_s1      <= {{EXT{second_x[COORD_BITS-1]}}, second_x}
			            - {{EXT{first_x[COORD_BITS-1]}}, first_x};
			dy_s1      <= {{EXT{second_y[COORD_BITS-1]}}, second_y}
			            - {{EXT{first_y[COORD_BITS-1]}}, first_y};
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: detect the degenerate cases and fold the left half-plane
	// onto the right one by a half-turn rotation. The OR of both
	// magnitudes has the same leading one as the larger of them.
	// ------------------------------------------------------------------
	logic                      v_s2;
	logic                      zero_s2;
	logic signed [DP_BITS-1:0] x_s2;
	logic signed [DP_BITS-1:0] y_s2;
	logic       [ACC_BITS-1:0] z_s2;
	logic      [NORM_BITS-1:0] m_s2;

	logic        [DP_BITS-1:0] abs_dx;
	logic        [DP_BITS-1:0] abs_dy;

	always_comb begin
		abs_dx = dx_s1[DP_BITS-1] ? DP_BITS'(-dx_s1) : DP_BITS'(dx_s1);
		abs_dy = dy_s1[DP_BITS-1] ? DP_BITS'(-dy_s1) : DP_BITS'(dy_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			zero_s2 <= !present_s1 || (dx_s1 == '0 && dy_s1 == '0);
			m_s2    <= abs_dx[NORM_BITS-1:0] | abs_dy[NORM_BITS-1:0];
			if (dx_s1[DP_BITS-1]) begin
				x_s2 <= -dx_s1;
				y_s2 <= -dy_s1;
				z_s2 <= HALF_TURN;
			end else begin
				x_s2 <= dx_s1;
				y_s2 <= dy_s1;
				z_s2 <= '0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stages 3 to 5: normalize so that the larger magnitude has its top
	// bit at NORM_MSB. Each stage tries two binary shift sizes; the six
	// sizes 32, 16, 8, 4, 2, 1 cover any shift up to 63.
	// ------------------------------------------------------------------
	logic                      v_s3, v_s4, v_s5;
	logic                      zero_s3, zero_s4, zero_s5;
	logic signed [DP_BITS-1:0] x_s3, x_s4, x_s5;
	logic signed [DP_BITS-1:0] y_s3, y_s4, y_s5;
	logic       [ACC_BITS-1:0] z_s3, z_s4, z_s5;
	logic      [NORM_BITS-1:0] m_s3, m_s4, m_s5;

	logic      [NORM_BITS-1:0] m_n3a, m_n3b, m_n4a, m_n4b, m_n5a, m_n5b;
	logic signed [DP_BITS-1:0] x_n3a, x_n3b, x_n4a, x_n4b, x_n5a, x_n5b;
	logic signed [DP_BITS-1:0] y_n3a, y_n3b, y_n4a, y_n4b, y_n5a, y_n5b;

	always_comb begin
		// Stage 3: shifts of 32 and 16.
		m_n3a = m_s2;
		x_n3a = x_s2;
		y_n3a = y_s2;
		if (m_s2[NORM_MSB -: 32] == '0) begin
			m_n3a = m_s2 << 32;
			x_n3a = x_s2 <<< 32;
			y_n3a = y_s2 <<< 32;
		end
		m_n3b = m_n3a;
		x_n3b = x_n3a;
		y_n3b = y_n3a;
		if (m_n3a[NORM_MSB -: 16] == '0) begin
			m_n3b = m_n3a << 16;
			x_n3b = x_n3a <<< 16;
			y_n3b = y_n3a <<< 16;
		end
		// Stage 4: shifts of 8 and 4.
		m_n4a = m_s3;
		x_n4a = x_s3;
		y_n4a = y_s3;
		if (m_s3[NORM_MSB -: 8] == '0) begin
			m_n4a = m_s3 << 8;
			x_n4a = x_s3 <<< 8;
			y_n4a = y_s3 <<< 8;
		end
		m_n4b = m_n4a;
		x_n4b = x_n4a;
		y_n4b = y_n4a;
		if (m_n4a[NORM_MSB -: 4] == '0) begin
			m_n4b = m_n4a << 4;
			x_n4b = x_n4a <<< 4;
			y_n4b = y_n4a <<< 4;
		end
		// Stage 5: shifts of 2 and 1.
		m_n5a = m_s4;
		x_n5a = x_s4;
		y_n5a = y_s4;
		if (m_s4[NORM_MSB -: 2] == '0) begin
			m_n5a = m_s4 << 2;
			x_n5a = x_s4 <<< 2;
			y_n5a = y_s4 <<< 2;
		end
		m_n5b = m_n5a;
		x_n5b = x_n5a;
		y_n5b = y_n5a;
		if (!m_n5a[NORM_MSB]) begin
			m_n5b = m_n5a << 1;
			x_n5b = x_n5a <<< 1;
			y_n5b = y_n5a <<< 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (advance) begin
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			zero_s3 <= zero_s2;
			z_s3    <= z_s2;
			m_s3    <= m_n3b;
			x_s3    <= x_n3b;
			y_s3    <= y_n3b;
			zero_s4 <= zero_s3;
			z_s4    <= z_s3;
			m_s4    <= m_n4b;
			x_s4    <= x_n4b;
			y_s4    <= y_n4b;
			zero_s5 <= zero_s4;
			z_s5    <= z_s4;
			m_s5    <= m_n5b;
			x_s5    <= x_n5b;
			y_s5    <= y_n5b;
		end
	end

	// ------------------------------------------------------------------
	// CORDIC vectoring chain: one register stage per rotation step. Each
	// step drives y toward zero and accumulates the matching angle.
	// Shifts round toward minus infinity (arithmetic shift).
	// ------------------------------------------------------------------
	logic                      crd_v_s    [N_STEPS];
	logic                      crd_zero_s [N_STEPS];
	logic signed [DP_BITS-1:0] crd_x_s    [N_STEPS];
	logic signed [DP_BITS-1:0] crd_y_s    [N_STEPS];
	logic       [ACC_BITS-1:0] crd_z_s    [N_STEPS];

	for (genvar i = 0; i < N_STEPS; i++) begin : g_step
		logic                      vi;
		logic                      zi;
		logic signed [DP_BITS-1:0] xi;
		logic signed [DP_BITS-1:0] yi;
		logic       [ACC_BITS-1:0] ai;
		logic signed [DP_BITS-1:0] xs;
		logic signed [DP_BITS-1:0] ys;

		if (i == 0) begin : g_first
			assign vi = v_s5;
			assign zi = zero_s5;
			assign xi = x_s5;
			assign yi = y_s5;
			assign ai = z_s5;
		end else begin : g_next
			assign vi = crd_v_s[i-1];
			assign zi = crd_zero_s[i-1];
			assign xi = crd_x_s[i-1];
			assign yi = crd_y_s[i-1];
			assign ai = crd_z_s[i-1];
		end

		assign xs = xi >>> i;
		assign ys = yi >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				crd_v_s[i] <= 1'b0;
			end else if (advance) begin
				crd_v_s[i] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				crd_zero_s[i] <= zi;
				if (!yi[DP_BITS-1]) begin
					crd_x_s[i] <= xi + ys;
					crd_y_s[i] <= yi - xs;
					crd_z_s[i] <= ai + TURN_ATAN[i];
				end else begin
					crd_x_s[i] <= xi - ys;
					crd_y_s[i] <= yi + xs;
					crd_z_s[i] <= ai - TURN_ATAN[i];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Output register: when ANGLE_BITS is below ACC_BITS, round the accumulator to
	// nearest, ties up, wrapping so that just under a full turn becomes zero.
	// Absent pairs and coincident points give zero.
	// ------------------------------------------------------------------
	logic                  out_valid_q;
	logic [ANGLE_BITS-1:0] heading_q;
	logic [ANGLE_BITS-1:0] rounded;

	if (ANGLE_BITS >= ACC_BITS) begin : g_full
		assign rounded = ANGLE_BITS'(crd_z_s[N_STEPS-1]);
	end else begin : g_round
		localparam int DROP = ACC_BITS - ANGLE_BITS;
		logic [ACC_BITS-1:0] sum;
		assign sum     = crd_z_s[N_STEPS-1] + (ACC_BITS'(1) << (DROP - 1));
		assign rounded = sum[ACC_BITS-1:DROP];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= crd_v_s[N_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			heading_q <= crd_zero_s[N_STEPS-1] ? '0 : rounded;
		end
	end

	assign out_valid = out_valid_q;
	assign heading   = heading_q;

`ifndef SYNTHESIS
	// The half-plane fold leaves a non-negative x for every real vector.
	a_fold_right: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !zero_s2) |-> !x_s2[DP_BITS-1])
		else $error("fold left a negative x");

	// After the normalize stages the larger magnitude sits at the window top.
	a_norm_top: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !zero_s5) |-> m_s5[NORM_MSB])
		else $error("normalization did not reach the top bit");

	// The rotated x stays positive and well inside the datapath width.
	a_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		(crd_v_s[N_STEPS-1] && !crd_zero_s[N_STEPS-1])
			|-> (crd_x_s[N_STEPS-1][DP_BITS-1 -: 2] == 2'b00
			&& crd_x_s[N_STEPS-1] != '0))
		else $error("rotation x out of range");

	// A result that is being held back freezes every stage behind it.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(crd_z_s[N_STEPS-1])))
		else $error("pipeline moved during a stall");
`endif

endmodule

// ----- verif/tb_heading_from_two_points_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_heading_from_two_points_top: self-checking bench for the heading unit
// Feeds point pairs through the valid/ready request channel. A directed table
// covers the corners and special cases, and random pairs follow. Every
// returned heading is compared in order against a known value or a behavioral
// CORDIC predictor, under three patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_heading_from_two_points_top;
	import hftp_pkg::*;

	localparam int COORD_BITS   = 32;
	localparam int ANGLE_BITS   = 16;
	localparam int CORDIC_STEPS = 16;

	localparam int HALF_PERIOD = 4;
	localparam int RESET_CYCLES = 10;
	// Covers the pipeline depth of the block, plus slack.
	localparam int DRAIN_CYCLES = CORDIC_STEPS + 6 + 16;
	// Leaves a wide margin over the slowest correct run.
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PER_PHASE = 610;

	localparam logic [COORD_BITS-1:0] C_MIN = 32'h8000_0000;
	localparam logic [COORD_BITS-1:0] C_MAX = 32'h7FFF_FFFF;
	localparam logic [COORD_BITS-1:0] C_NEG1 = 32'hFFFF_FFFF;

	// One point pair request. When known is set, heading holds the result
	// that can be read off directly; otherwise the predictor supplies it.
	typedef struct packed {
		logic                  present;
		logic [COORD_BITS-1:0] first_x;
		logic [COORD_BITS-1:0] first_y;
		logic [COORD_BITS-1:0] second_x;
		logic [COORD_BITS-1:0] second_y;
		logic                  known;
		logic [ANGLE_BITS-1:0] heading;
	} pair_row_t;

	typedef struct packed {
		int unsigned           tag;
		logic [ANGLE_BITS-1:0] heading;
	} heading_due_t;

	localparam int DIRECTED_ROWS = 24;

	// Columns: present, first x, first y, second x, second y, known, heading.
	localparam pair_row_t DIRECTED [DIRECTED_ROWS] = '{
		// A missing pair always reads zero, whatever the coordinates say.
		'{1'b0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 1'b1, 16'h0000},
		'{1'b0, C_MIN, C_MAX, C_MAX, C_MIN, 1'b1, 16'h0000},
		// Coincident points have no angle and also read zero.
		'{1'b1, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 16'h0000},
		'{1'b1, C_MIN, C_MIN, C_MIN, C_MIN, 1'b1, 16'h0000},
		'{1'b1, C_MAX, C_MAX, C_MAX, C_MAX, 1'b1, 16'h0000},
		// The four axis directions and the four diagonals.
		'{1'b1, 32'h0, 32'h0, 32'h1, 32'h0, 1'b0, 16'h0000},
		'{1'b1, 32'h0, 32'h0, 32'h0, 32'h1, 1'b0, 16'h0000},
		'{1'b1, 32'h0, 32'h0, C_NEG1, 32'h0, 1'b0, 16'h0000},
		'{1'b1, 32'h0, 32'h0, 32'h0, C_NEG1, 1'b0, 16'h0000},
		'{1'b1, 32'h0, 32'h0, 32'h1, 32'h1, 1'b0, 16'h0000},
		'{1'b1, 32'h0, 32'h0, C_NEG1, 32'h1, 1'b0, 16'h0000},
		'{1'b1, 32'h0, 32'h0, C_NEG1, C_NEG1, 1'b0, 16'h0000},
		'{1'b1, 32'h0, 32'h0, 32'h1, C_NEG1, 1'b0, 16'h0000},
		// Differences at the full 33-bit reach in each direction.
		'{1'b1, C_MIN, 32'h0, C_MAX, 32'h0, 1'b0, 16'h0000},
		'{1'b1, C_MAX, 32'h0, C_MIN, 32'h0, 1'b0, 16'h0000},
		'{1'b1, 32'h0, C_MIN, 32'h0, C_MAX, 1'b0, 16'h0000},
		'{1'b1, 32'h0, C_MAX, 32'h0, C_MIN, 1'b0, 16'h0000},
		'{1'b1, C_MIN, C_MIN, C_MAX, C_MAX, 1'b0, 16'h0000},
		'{1'b1, C_MAX, C_MIN, C_MIN, C_MAX, 1'b0, 16'h0000},
		'{1'b1, C_MAX, C_MAX, C_MIN, C_MIN, 1'b0, 16'h0000},
		// Shallow vectors: just above the x axis, either side of the half
		// turn, and just below a full turn, where rounding wraps to zero.
		'{1'b1, 32'h0, 32'h0, C_MAX, 32'h1, 1'b0, 16'h0000},
		'{1'b1, 32'h0, 32'h0, C_MIN, C_NEG1, 1'b0, 16'h0000},
		'{1'b1, 32'h0, 32'h0, C_MIN, 32'h1, 1'b0, 16'h0000},
		'{1'b1, 32'h0, 32'h0, C_MAX, C_NEG1, 1'b0, 16'h0000}
	};

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	logic                         pair_present;
	logic signed [COORD_BITS-1:0] first_x;
	logic signed [COORD_BITS-1:0] first_y;
	logic signed [COORD_BITS-1:0] second_x;
	logic signed [COORD_BITS-1:0] second_y;
	logic                         out_valid;
	logic                         out_ready;
	logic        [ANGLE_BITS-1:0] heading;

	heading_due_t pending_headings [$];
	int unsigned  request_count = 0;
	int unsigned  mismatch_count = 0;
	int unsigned  cycle_count = 0;
	int unsigned  send_idle_pct = 0;
	int unsigned  recv_idle_pct = 0;

	heading_from_two_points_top #(
		.COORD_BITS  (COORD_BITS),
		.ANGLE_BITS  (ANGLE_BITS),
		.CORDIC_STEPS(CORDIC_STEPS)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pair_present(pair_present),
		.first_x     (first_x),
		.first_y     (first_y),
		.second_x    (second_x),
		.second_y    (second_y),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.heading     (heading)
	);

	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	// Prints one line per mismatch and keeps the tally for the final verdict.
	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("ERROR @%0t: %s", $realtime, what);
	endtask

	// Behavioral heading: fold the left half-plane, scale the difference up
	// to the normalization window, run the vectoring steps in 64-bit signed
	// arithmetic, and round the 32-bit turn accumulator to ANGLE_BITS.
	function automatic logic [ANGLE_BITS-1:0] heading_of_pair(
		input logic                  present,
		input logic [COORD_BITS-1:0] fx,
		input logic [COORD_BITS-1:0] fy,
		input logic [COORD_BITS-1:0] sx,
		input logic [COORD_BITS-1:0] sy
	);
		longint signed dx;
		longint signed dy;
		longint signed mag_x;
		longint signed mag_y;
		longint signed big;
		longint signed xs;
		longint signed ys;
		logic [ACC_BITS-1:0] turn;
		dx = longint'($signed(sx)) - longint'($signed(fx));
		dy = longint'($signed(sy)) - longint'($signed(fy));
		turn = '0;
		if (!present || (dx == 0 && dy == 0))
			return '0;
		if (dx < 0) begin
			dx = -dx;
			dy = -dy;
			turn = HALF_TURN;
		end
		mag_x = dx;
		mag_y = (dy < 0) ? -dy : dy;
		big = (mag_x > mag_y) ? mag_x : mag_y;
		while (big < (longint'(1) <<< NORM_MSB)) begin
			dx = dx * 2;
			dy = dy * 2;
			big = big * 2;
		end
		for (int i = 0; i < CORDIC_STEPS && i < MAX_STEPS; i++) begin
			// Arithmetic shift on a signed value rounds toward minus infinity.
			xs = dx >>> i;
			ys = dy >>> i;
			if (dy >= 0) begin
				dx = dx + ys;
				dy = dy - xs;
				turn = turn + TURN_ATAN[i];
			end else begin
				dx = dx - ys;
				dy = dy + xs;
				turn = turn - TURN_ATAN[i];
			end
		end
		// Round half up; the add wraps, so a hair below a full turn gives zero.
		turn = turn + (ACC_BITS'(1) << (ACC_BITS - ANGLE_BITS - 1));
		return turn[ACC_BITS-1 -: ANGLE_BITS];
	endfunction

	// One of the awkward coordinate values, or occasionally a random one.
	function automatic logic [COORD_BITS-1:0] corner_coord();
		case ($urandom_range(5))
			0: return C_MIN;
			1: return C_MAX;
			2: return '0;
			3: return C_NEG1;
			4: return COORD_BITS'(1);
			default: return $urandom();
		endcase
	endfunction

	// Random point pair. Most are fully random or close neighbors; the rest
	// hit a missing pair, coincident points, or corner coordinates.
	function automatic pair_row_t random_pair();
		pair_row_t row;
		int unsigned pick;
		int unsigned span;
		int delta_x;
		int delta_y;
		row = '0;
		pick = $urandom_range(99);
		span = $urandom_range(30);
		row.present = 1'b1;
		row.first_x = $urandom();
		row.first_y = $urandom();
		row.second_x = $urandom();
		row.second_y = $urandom();
		if (pick < 5) begin
			row.present = 1'b0;
		end else if (pick < 10) begin
			row.second_x = row.first_x;
			row.second_y = row.first_y;
		end else if (pick < 22) begin
			row.first_x = corner_coord();
			row.first_y = corner_coord();
			row.second_x = corner_coord();
			row.second_y = corner_coord();
		end else if (pick < 55) begin
			// Short vectors in every direction exercise the normalization
			// shift over its range.
			delta_x = $signed($urandom()) >>> span;
			delta_y = $signed($urandom()) >>> span;
			row.second_x = row.first_x + COORD_BITS'(delta_x);
			row.second_y = row.first_y + COORD_BITS'(delta_y);
		end
		return row;
	endfunction

	// Presents one request and holds it until the handshake completes. An
	// idle gap may come first; when there is none, valid simply stays high.
	task automatic send_pair(input pair_row_t row);
		heading_due_t due;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		pair_present <= row.present;
		first_x      <= row.first_x;
		first_y      <= row.first_y;
		second_x     <= row.second_x;
		second_y     <= row.second_y;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		due.tag = request_count;
		due.heading = row.known ? row.heading
			: heading_of_pair(row.present, row.first_x, row.first_y,
				row.second_x, row.second_y);
		pending_headings.push_back(due);
		request_count++;
	endtask

	// Receiver back-pressure, redrawn every cycle.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Every accepted heading is matched against the oldest outstanding request.
	always @(posedge clk) begin : check_heading
		heading_due_t due;
		if (arst_n && out_valid && out_ready) begin
			if (pending_headings.size() == 0) begin
				report_mismatch($sformatf("heading %h with no request outstanding",
					heading));
			end else begin
				due = pending_headings.pop_front();
				if (heading !== due.heading)
					report_mismatch($sformatf("request %0d: heading %h, expected %h",
						due.tag, heading, due.heading));
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("ERROR: no progress after %0d cycles, %0d headings outstanding",
				cycle_count, pending_headings.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		out_ready    = 1'b0;
		pair_present = 1'b0;
		first_x      = '0;
		first_y      = '0;
		second_x     = '0;
		second_y     = '0;

		// Release reset away from the rising edge so the flops see it cleanly.
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// First pattern: the sender is the lighter idler, the receiver the heavier.
		// The directed table runs under it before the random requests.
		send_idle_pct = 36;
		recv_idle_pct = 57;
		for (int r = 0; r < DIRECTED_ROWS; r++)
			send_pair(DIRECTED[r]);
		for (int n = 0; n < RANDOM_PER_PHASE; n++)
			send_pair(random_pair());

		// Swap the two idle rates.
		send_idle_pct = 57;
		recv_idle_pct = 36;
		for (int n = 0; n < RANDOM_PER_PHASE; n++)
			send_pair(random_pair());

		// Back-to-back requests with the receiver always ready.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int n = 0; n < RANDOM_PER_PHASE; n++)
			send_pair(random_pair());
		in_valid <= 1'b0;

		// Drain, then give any stray result time to show up.
		while (pending_headings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/hftp_pkg.sv
rtl/heading_from_two_points_top.sv
verif/tb_heading_from_two_points_top.sv
